@@ design/tcw_pkg.sv @@
// Shared types, constants and helper functions for the text console writer.
// Used by tcw_front, tcw_fifo, tcw_back and text_console_writer_unit.
`default_nettype none

package tcw_pkg;

  // Screen geometry and tab spacing (TAB_STOP is a power of two).
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  // Field widths of the request and result items.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int TCNT_W = $clog2(TAB_STOP + 1);

  // Stream widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  // Command queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Command classes produced by the front end.
  localparam logic [2:0] CL_CHAR  = 3'd0;
  localparam logic [2:0] CL_NL    = 3'd1;
  localparam logic [2:0] CL_CR    = 3'd2;
  localparam logic [2:0] CL_TAB   = 3'd3;
  localparam logic [2:0] CL_READ  = 3'd4;
  localparam logic [2:0] CL_CLEAR = 3'd5;
  localparam logic [2:0] CL_NOP   = 3'd6;

  // Classified command as it travels through the queue.
  typedef struct packed {
    logic [2:0]        cls;
    logic              put;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  // Physical row of a logical row, given the row that is currently on top.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Linear cell index of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

@@ design/tcw_fifo.sv @@
// Short command queue that decouples the front end from the execution back end.
// Depends on tcw_pkg for the command type and queue depth.
`default_nettype none

module tcw_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  tcw_pkg::cmd_t    push_data,
  output logic             full,
  input  wire              pop,
  output tcw_pkg::cmd_t    pop_data,
  output logic             empty
);

  tcw_pkg::cmd_t                  entry_r [tcw_pkg::FIFO_DEPTH];
  logic [tcw_pkg::FIFO_PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::FIFO_PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::FIFO_PW:0]      count_r, count_nxt;

  assign full     = (count_r == (tcw_pkg::FIFO_PW+1)'(tcw_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/tcw_front.sv @@
// Front end: accepts requests from the input stream and classifies them.
// Depends on tcw_pkg; feeds tcw_fifo.
`default_nettype none

module tcw_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // in_tdata, from bit 0 up: char_code[7:0], cell_col[14:8], cell_row[19:15], zero pad
  input  wire [tcw_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: operation[1:0]
  input  wire [tcw_pkg::IN_USER_W-1:0]     in_tuser,
  input  wire                              init_busy,
  input  wire                              fifo_full,
  output logic                             push,
  output tcw_pkg::cmd_t                    push_data
);

  tcw_pkg::cmd_t hold_r, decoded;
  logic          hold_valid_r, hold_valid_nxt;
  logic          accept;

  // Classify the incoming request.
  always_comb begin
    decoded.ch  = in_tdata[7:0];
    decoded.col = in_tdata[14:8];
    decoded.row = in_tdata[19:15];
    decoded.put = 1'b0;
    unique case (in_tuser)
      tcw_pkg::OP_PUT: begin
        decoded.put = 1'b1;
        unique case (in_tdata[7:0])
          tcw_pkg::CH_NL:  decoded.cls = tcw_pkg::CL_NL;
          tcw_pkg::CH_CR:  decoded.cls = tcw_pkg::CL_CR;
          tcw_pkg::CH_TAB: decoded.cls = tcw_pkg::CL_TAB;
          default:         decoded.cls = tcw_pkg::CL_CHAR;
        endcase
      end
      tcw_pkg::OP_READ:  decoded.cls = tcw_pkg::CL_READ;
      tcw_pkg::OP_CLEAR: decoded.cls = tcw_pkg::CL_CLEAR;
      default:           decoded.cls = tcw_pkg::CL_NOP;
    endcase
  end

  // One holding stage in front of the queue.
  assign push      = hold_valid_r && !fifo_full;
  assign push_data = hold_r;
  assign in_tready = !init_busy && (!hold_valid_r || !fifo_full);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= decoded;
    end
  end

endmodule

`default_nettype wire

@@ design/tcw_back.sv @@
// Back end: executes queued commands against the cell store and the cursor.
// Depends on tcw_pkg; holds the default colour register and the result register.
`default_nettype none

module tcw_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [tcw_pkg::CHAR_W-1:0]        cfg_wdata,
  input  wire                              fifo_empty,
  output logic                             pop,
  input  tcw_pkg::cmd_t                    head,
  output logic                             init_busy,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [tcw_pkg::OUT_USER_W-1:0]   out_tuser
);

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int CHAR_W = tcw_pkg::CHAR_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int TCNT_W = tcw_pkg::TCNT_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [ROW_W-1:0]   blank_row_r, blank_row_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [TCNT_W-1:0]  spaces_r, spaces_nxt;
  logic [CHAR_W-1:0]  store_ch_r, store_ch_nxt;
  logic               init_r, init_nxt;
  logic               cell_ok_r, cell_ok_nxt;
  logic [CHAR_W-1:0]  color_r;
  tcw_pkg::cmd_t      cmd_r;

  // Cell store, split into character and attribute bytes.
  logic [CHAR_W-1:0]  char_mem  [tcw_pkg::CELLS];
  logic [CHAR_W-1:0]  color_mem [tcw_pkg::CELLS];
  logic [CHAR_W-1:0]  rd_char_r, rd_color_r;
  logic               char_we, color_we, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CHAR_W-1:0]  wr_char, wr_color;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  logic [tcw_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [tcw_pkg::OUT_USER_W-1:0] out_user_r;
  logic                          out_load;

  // Helpers for cursor movement.
  logic [COL_W:0]     col_inc;
  logic               col_wrap, last_row, nl_step, in_range;
  logic [ROW_W:0]     top_inc;
  logic [ADDR_W-1:0]  blank_addr;
  logic [TCNT_W-1:0]  tab_spaces;
  logic [CHAR_W-1:0]  res_char, res_color, res_echo;

  assign col_inc    = {1'b0, cur_col_r} + 1'b1;
  assign col_wrap   = (col_inc == (COL_W+1)'(tcw_pkg::COLUMNS));
  assign last_row   = (cur_row_r == ROW_W'(tcw_pkg::ROWS - 1));
  assign top_inc    = {1'b0, top_r} + 1'b1;
  assign blank_addr = ADDR_W'(blank_row_r) * ADDR_W'(tcw_pkg::COLUMNS) + cnt_r;
  assign tab_spaces = TCNT_W'(tcw_pkg::TAB_STOP) - TCNT_W'(cur_col_r % tcw_pkg::TAB_STOP);
  assign in_range   = (32'(cmd_r.col) < tcw_pkg::COLUMNS) && (32'(cmd_r.row) < tcw_pkg::ROWS);

  assign pop        = (state_r == ST_IDLE) && !fifo_empty;
  assign init_busy  = (state_r == ST_CLEAR) && init_r;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    top_nxt       = top_r;
    blank_row_nxt = blank_row_r;
    cnt_nxt       = cnt_r;
    spaces_nxt    = spaces_r;
    store_ch_nxt  = store_ch_r;
    init_nxt      = init_r;
    cell_ok_nxt   = cell_ok_r;
    char_we       = 1'b0;
    color_we      = 1'b0;
    wr_addr       = cnt_r;
    wr_char       = '0;
    wr_color      = color_r;
    rd_en         = 1'b0;
    rd_addr       = tcw_pkg::cell_addr(tcw_pkg::phys_row(cmd_r.row, top_r), cmd_r.col);
    nl_step       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        spaces_nxt = '0;
        case (cmd_r.cls)
          tcw_pkg::CL_CHAR: begin
            spaces_nxt   = TCNT_W'(1);
            store_ch_nxt = cmd_r.ch;
            state_nxt    = ST_STORE;
          end
          tcw_pkg::CL_TAB: begin
            spaces_nxt   = tab_spaces;
            store_ch_nxt = tcw_pkg::CH_SPACE;
            state_nxt    = ST_STORE;
          end
          tcw_pkg::CL_NL: begin
            cur_col_nxt = '0;
            nl_step     = 1'b1;
            state_nxt   = last_row ? ST_BLANK : ST_DONE;
          end
          tcw_pkg::CL_CR: begin
            cur_col_nxt = '0;
            state_nxt   = ST_DONE;
          end
          tcw_pkg::CL_READ: begin
            rd_en       = in_range;
            cell_ok_nxt = in_range;
            state_nxt   = ST_DONE;
          end
          tcw_pkg::CL_CLEAR: begin
            cnt_nxt   = '0;
            state_nxt = ST_CLEAR;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Store one character at the cursor and advance.
      ST_STORE: begin
        char_we    = 1'b1;
        wr_addr    = tcw_pkg::cell_addr(tcw_pkg::phys_row(cur_row_r, top_r), cur_col_r);
        wr_char    = store_ch_r;
        spaces_nxt = spaces_r - 1'b1;
        if (col_wrap) begin
          cur_col_nxt = '0;
          nl_step     = 1'b1;
        end else begin
          cur_col_nxt = col_inc[COL_W-1:0];
        end
        if (col_wrap && last_row) begin
          state_nxt = ST_BLANK;
        end else if (spaces_r == TCNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end

      // Blank the new bottom row after a scroll.
      ST_BLANK: begin
        char_we  = 1'b1;
        color_we = 1'b1;
        wr_addr  = blank_addr;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(tcw_pkg::COLUMNS - 1)) begin
          state_nxt = (spaces_r != '0) ? ST_STORE : ST_DONE;
        end
      end

      // Blank the whole store, after reset or on a clear request.
      ST_CLEAR: begin
        char_we  = 1'b1;
        color_we = 1'b1;
        wr_addr  = cnt_r;
        wr_color = init_r ? tcw_pkg::RESET_COLOR : color_r;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(tcw_pkg::CELLS - 1)) begin
          top_nxt     = '0;
          cur_col_nxt = '0;
          cur_row_nxt = '0;
          init_nxt    = 1'b0;
          state_nxt   = init_r ? ST_IDLE : ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Move to the next row, scrolling by rotating the top row when at the bottom.
    if (nl_step) begin
      if (last_row) begin
        top_nxt       = (top_inc == (ROW_W+1)'(tcw_pkg::ROWS)) ? '0 : top_inc[ROW_W-1:0];
        blank_row_nxt = top_r;
        cnt_nxt       = '0;
      end else begin
        cur_row_nxt = cur_row_r + 1'b1;
      end
    end
  end

  // Result fields.
  assign res_char  = (cmd_r.cls == tcw_pkg::CL_READ && cell_ok_r) ? rd_char_r : '0;
  assign res_color = (cmd_r.cls == tcw_pkg::CL_READ && cell_ok_r) ? rd_color_r : '0;
  assign res_echo  = cmd_r.put ? cmd_r.ch : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      spaces_r    <= '0;
      out_valid_r <= 1'b0;
      color_r     <= tcw_pkg::RESET_COLOR;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cnt_r       <= cnt_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      top_r       <= top_nxt;
      spaces_r    <= spaces_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blank_row_r <= blank_row_nxt;
    store_ch_r  <= store_ch_nxt;
    cell_ok_r   <= cell_ok_nxt;
    if (pop) begin
      cmd_r <= head;
    end
    if (out_load) begin
      out_data_r <= {1'b0, res_color, res_char, res_echo,
                     tcw_pkg::cell_addr(cur_row_r, cur_col_r), cur_row_r, cur_col_r};
      out_user_r <= cmd_r.put;
    end
  end

  // Cell store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (color_we) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (rd_en) begin
      rd_char_r  <= char_mem[rd_addr];
      rd_color_r <= color_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/text_console_writer_unit.sv @@
// Text console writer, 80x25 cells.
// The back-end sequencer stores a character in ST_STORE and takes a read, CR or newline
// straight from ST_EXEC to ST_DONE; a tab stores n spaces, a scroll adds row blanking,
// and a clear blanks all COLUMNS*ROWS cells, one cell store write per cycle.
// After reset a clearing pass runs with in_tready low; config is taken.
`default_nettype none

module text_console_writer_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // in_tdata, from bit 0 up: char_code[7:0], cell_col[14:8], cell_row[19:15], zero pad
  input  wire [tcw_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: operation[1:0]
  input  wire [tcw_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // out_tdata, from bit 0 up: cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
  // echo_byte[30:23], cell_char[38:31], cell_color[46:39], zero pad
  output logic [tcw_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: echo_valid[0]
  output logic [tcw_pkg::OUT_USER_W-1:0]   out_tuser,
  input  wire                              cfg_we,
  input  wire [tcw_pkg::CHAR_W-1:0]        cfg_wdata
);

  logic          init_busy;
  logic          fifo_full, fifo_empty;
  logic          push, pop;
  tcw_pkg::cmd_t push_data, head;

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_busy (init_busy),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  tcw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (fifo_empty)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .head       (head),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // No request is taken while the power-on clearing pass runs.
  assert property (@(posedge clk) disable iff (!rst_n) init_busy |-> !in_tready)
    else $error("request taken during the clearing pass");

  // The queue is never written while full.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !fifo_full)
    else $error("command queue overflow");

  // A reported cursor always lies on the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[6:0]) < tcw_pkg::COLUMNS) &&
                   (32'(out_tdata[11:7]) < tcw_pkg::ROWS))
    else $error("cursor off screen");

  // The linear cursor agrees with the row and column.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:12] == tcw_pkg::cell_addr(out_tdata[11:7], out_tdata[6:0]))
    else $error("linear cursor mismatch");

endmodule

`default_nettype wire
